/* rtl/i2c_register_table_slave_defines.svh */
// Assertion helpers used by i2crt_ctrl.
`ifndef I2C_REGISTER_TABLE_SLAVE_DEFINES_SVH
`define I2C_REGISTER_TABLE_SLAVE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define I2CRT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define I2CRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/i2crt_pkg.sv */
package i2crt_pkg;

  localparam int unsigned NUM_REGS_DEF  = 8;
  localparam int unsigned BUF_DEPTH_DEF = 16;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [3:0] TABLE_ENTRIES_RST = 4'd8;
  localparam logic [7:0] TX_FILL           = 8'hFF;

  localparam logic CFG_TABLE_ENTRIES = 1'b0;

  typedef enum logic [2:0] {
    OP_BUS        = 3'd0,
    OP_LOAD_TX    = 3'd1,
    OP_READ_RX    = 3'd2,
    OP_SET_RX_LEN = 3'd3,
    OP_SET_TX_LEN = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    EVT_ADDR_RD = 3'd0,
    EVT_ADDR_WR = 3'd1,
    EVT_RD_DATA = 3'd2,
    EVT_WR_DATA = 3'd3,
    EVT_STOP    = 3'd4,
    EVT_ERROR   = 3'd5
  } evt_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic       addr_stop_flag;
    logic       addr_match;
    logic       read_dir;
    logic       data_flag;
    logic       collision;
    logic       bus_fault;
    logic [7:0] data_byte;
    logic [2:0] reg_select;
    logic [3:0] byte_offset;
  } in_req_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic       complete;
    logic [7:0] out_byte;
    logic       out_valid;
  } out_rsp_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

endpackage

/* rtl/i2crt_cfg.sv */
module i2crt_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2crt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [i2crt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [i2crt_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output logic [3:0]                          table_entries_o
);

  logic [3:0] table_entries_q;
  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[i2crt_pkg::CFG_ADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_entries_q <= i2crt_pkg::TABLE_ENTRIES_RST;
    end else if (wr_en && (reg_idx == i2crt_pkg::CFG_TABLE_ENTRIES)) begin
      table_entries_q <= pwdata[3:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      i2crt_pkg::CFG_TABLE_ENTRIES: begin
        prdata = i2crt_pkg::CFG_DATA_W'(table_entries_q);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign table_entries_o = table_entries_q;

endmodule

/* rtl/i2crt_dp.sv */
module i2crt_dp #(
  parameter int unsigned NUM_REGS  = i2crt_pkg::NUM_REGS_DEF,
  parameter int unsigned BUF_DEPTH = i2crt_pkg::BUF_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2crt_pkg::ctrl_cmd_t  cmd_i,
  output i2crt_pkg::dp_status_t status_o,
  input  logic [3:0]            table_entries_i,
  input  i2crt_pkg::in_req_t    in_req_i,
  output i2crt_pkg::out_rsp_t   out_rsp_o
);

  localparam int unsigned StoreSize = NUM_REGS * BUF_DEPTH;
  localparam int unsigned AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int unsigned RegW      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned PosW      = $clog2(BUF_DEPTH + 1);

  logic [7:0]      rx_mem     [StoreSize];
  logic [7:0]      tx_mem     [StoreSize];
  logic [PosW-1:0] rx_len_mem [NUM_REGS];
  logic [PosW-1:0] tx_len_mem [NUM_REGS];

  i2crt_pkg::in_req_t  req_q;
  i2crt_pkg::out_rsp_t rsp_q, rsp_d;
  i2crt_pkg::evt_e     kind;

  logic            pend_q, pend_d;
  logic [RegW-1:0] cur_q, cur_d;
  logic [PosW-1:0] rx_pos_q, rx_pos_d;
  logic [PosW-1:0] tx_pos_q, tx_pos_d;
  logic [PosW-1:0] rx_lim_q, rx_lim_d;
  logic [PosW-1:0] tx_lim_q, tx_lim_d;
  logic [AddrW-1:0] clr_cnt_q;

  logic [7:0]      rx_rd_q, tx_rd_q;
  logic [PosW-1:0] rx_len_rd_q, tx_len_rd_q;
  logic [RegW-1:0] sel_q, sel_d;

  logic [AddrW-1:0] in_loc_addr;
  logic [AddrW-1:0] tx_addr;

  logic [7:0]       rs8;
  logic [RegW-1:0]  reg_idx;
  logic [AddrW-1:0] loc_addr;
  logic [AddrW-1:0] rx_addr;
  logic             loc_ok, reg_ok;
  logic             tx_avail, rx_room;
  logic [PosW-1:0]  len_clamp;

  logic             rx_we_bus, tx_we_loc, rxl_we_loc, txl_we_loc;
  logic             rx_we, tx_we, rxl_we, txl_we;
  logic [AddrW-1:0] rx_wa, tx_wa;
  logic [7:0]       rx_wd, tx_wd;
  logic             clr_len;
  logic [RegW-1:0]  len_wa;
  logic [PosW-1:0]  len_wd;

  // request side: addresses for the registered reads
  assign in_loc_addr = AddrW'(in_req_i.reg_select * BUF_DEPTH) +
                       AddrW'(in_req_i.byte_offset);
  assign tx_addr     = AddrW'(cur_q * BUF_DEPTH) + AddrW'(tx_pos_q);

  always_comb begin
    if ((9'(in_req_i.data_byte) < 9'(table_entries_i)) &&
        (9'(in_req_i.data_byte) < 9'(NUM_REGS))) begin
      sel_d = in_req_i.data_byte[RegW-1:0];
    end else begin
      sel_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_req_i;
      sel_q <= sel_d;
    end
  end

  // execute side
  assign rs8       = 8'(req_q.reg_select);
  assign reg_idx   = rs8[RegW-1:0];
  assign reg_ok    = 9'(req_q.reg_select) < 9'(NUM_REGS);
  assign loc_ok    = reg_ok && (8'(req_q.byte_offset) < 8'(BUF_DEPTH));
  assign loc_addr  = AddrW'(req_q.reg_select * BUF_DEPTH) + AddrW'(req_q.byte_offset);
  assign rx_addr   = AddrW'(cur_q * BUF_DEPTH) + AddrW'(rx_pos_q);
  assign tx_avail  = (tx_pos_q < tx_lim_q) && (9'(tx_pos_q) < 9'(BUF_DEPTH));
  assign rx_room   = (rx_pos_q < rx_lim_q) && (9'(rx_pos_q) < 9'(BUF_DEPTH));
  assign len_clamp = (9'(req_q.data_byte) > 9'(BUF_DEPTH)) ? PosW'(BUF_DEPTH)
                                                           : PosW'(req_q.data_byte);

  always_comb begin
    if (req_q.collision || req_q.bus_fault) begin
      kind = i2crt_pkg::EVT_ERROR;
    end else if (req_q.addr_stop_flag) begin
      if (req_q.addr_match) begin
        kind = req_q.read_dir ? i2crt_pkg::EVT_ADDR_RD : i2crt_pkg::EVT_ADDR_WR;
      end else begin
        kind = i2crt_pkg::EVT_STOP;
      end
    end else if (req_q.data_flag) begin
      kind = req_q.read_dir ? i2crt_pkg::EVT_RD_DATA : i2crt_pkg::EVT_WR_DATA;
    end else begin
      kind = i2crt_pkg::EVT_ERROR;
    end
  end

  always_comb begin
    pend_d     = pend_q;
    cur_d      = cur_q;
    rx_pos_d   = rx_pos_q;
    tx_pos_d   = tx_pos_q;
    rx_lim_d   = rx_lim_q;
    tx_lim_d   = tx_lim_q;
    rsp_d      = '0;
    rx_we_bus  = 1'b0;
    tx_we_loc  = 1'b0;
    rxl_we_loc = 1'b0;
    txl_we_loc = 1'b0;
    case (req_q.opcode)
      i2crt_pkg::OP_BUS: begin
        rsp_d.event_kind = 3'(kind);
        case (kind)
          i2crt_pkg::EVT_ADDR_WR: begin
            pend_d = 1'b1;
          end
          i2crt_pkg::EVT_RD_DATA: begin
            rsp_d.out_valid = 1'b1;
            if (tx_avail) begin
              rsp_d.out_byte = tx_rd_q;
              tx_pos_d       = tx_pos_q + 1'b1;
            end else begin
              rsp_d.out_byte = i2crt_pkg::TX_FILL;
            end
          end
          i2crt_pkg::EVT_WR_DATA: begin
            if (pend_q) begin
              cur_d    = sel_q;
              rx_lim_d = rx_len_rd_q;
              tx_lim_d = tx_len_rd_q;
              rx_pos_d = '0;
              tx_pos_d = '0;
              pend_d   = 1'b0;
            end else if (rx_room) begin
              rx_we_bus = 1'b1;
              rx_pos_d  = rx_pos_q + 1'b1;
            end
          end
          i2crt_pkg::EVT_STOP, i2crt_pkg::EVT_ERROR: begin
            rsp_d.complete = 1'b1;
          end
          default: begin
          end
        endcase
      end
      i2crt_pkg::OP_LOAD_TX: begin
        tx_we_loc = loc_ok;
      end
      i2crt_pkg::OP_READ_RX: begin
        rsp_d.out_valid = 1'b1;
        rsp_d.out_byte  = loc_ok ? rx_rd_q : 8'h00;
      end
      i2crt_pkg::OP_SET_RX_LEN: begin
        rxl_we_loc = reg_ok;
      end
      i2crt_pkg::OP_SET_TX_LEN: begin
        txl_we_loc = reg_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      cur_q    <= '0;
      rx_pos_q <= '0;
      tx_pos_q <= '0;
      rx_lim_q <= '0;
      tx_lim_q <= '0;
    end else if (cmd_i.commit) begin
      pend_q   <= pend_d;
      cur_q    <= cur_d;
      rx_pos_q <= rx_pos_d;
      tx_pos_q <= tx_pos_d;
      rx_lim_q <= rx_lim_d;
      tx_lim_q <= tx_lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign status_o.clr_last = (32'(clr_cnt_q) == (StoreSize - 1));

  // memory write ports
  assign rx_we   = cmd_i.clear || (cmd_i.commit && rx_we_bus);
  assign rx_wa   = cmd_i.clear ? clr_cnt_q : rx_addr;
  assign rx_wd   = cmd_i.clear ? 8'h00 : req_q.data_byte;
  assign tx_we   = cmd_i.clear || (cmd_i.commit && tx_we_loc);
  assign tx_wa   = cmd_i.clear ? clr_cnt_q : loc_addr;
  assign tx_wd   = cmd_i.clear ? 8'h00 : req_q.data_byte;
  assign clr_len = cmd_i.clear && (32'(clr_cnt_q) < NUM_REGS);
  assign rxl_we  = clr_len || (cmd_i.commit && rxl_we_loc);
  assign txl_we  = clr_len || (cmd_i.commit && txl_we_loc);
  assign len_wa  = cmd_i.clear ? clr_cnt_q[RegW-1:0] : reg_idx;
  assign len_wd  = cmd_i.clear ? '0 : len_clamp;

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_wa] <= rx_wd;
    end
    if (cmd_i.accept) begin
      rx_rd_q <= rx_mem[in_loc_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_wa] <= tx_wd;
    end
    if (cmd_i.accept) begin
      tx_rd_q <= tx_mem[tx_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rxl_we) begin
      rx_len_mem[len_wa] <= len_wd;
    end
    if (cmd_i.accept) begin
      rx_len_rd_q <= rx_len_mem[sel_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (txl_we) begin
      tx_len_mem[len_wa] <= len_wd;
    end
    if (cmd_i.accept) begin
      tx_len_rd_q <= tx_len_mem[sel_d];
    end
  end

  assign out_rsp_o = rsp_q;

endmodule

/* rtl/i2crt_ctrl.sv */
`include "i2c_register_table_slave_defines.svh"

module i2crt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2crt_pkg::ctrl_cmd_t  cmd_o,
  input  i2crt_pkg::dp_status_t status_i
);

  i2crt_pkg::ctrl_state_e state_q, state_d;
  logic                   out_valid_q;
  logic                   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2crt_pkg::ST_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = i2crt_pkg::ST_IDLE;
        end
      end
      i2crt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = i2crt_pkg::ST_EXEC;
        end
      end
      i2crt_pkg::ST_EXEC: begin
        if (slot_free) begin
          state_d = i2crt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i2crt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      i2crt_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      i2crt_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      i2crt_pkg::ST_EXEC: begin
        cmd_o.commit = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2crt_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `I2CRT_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, in_valid_i && in_ready_o,
                     state_q == i2crt_pkg::ST_EXEC, "accepted request did not start execution")
  `I2CRT_ASSERT_NEXT(a_commit_valid, clk_i, rst_ni, cmd_o.commit, out_valid_q,
                     "committed result not presented")
  `I2CRT_ASSERT_NEXT(a_clear_hold, clk_i, rst_ni,
                     state_q == i2crt_pkg::ST_CLEAR && !status_i.clr_last,
                     state_q == i2crt_pkg::ST_CLEAR, "clearing sweep left early")
  `I2CRT_ASSERT(a_stall_hold, clk_i, rst_ni,
                (state_q == i2crt_pkg::ST_EXEC && out_valid_q && !out_ready_i) |=>
                (state_q == i2crt_pkg::ST_EXEC && out_valid_q),
                "stalled execution dropped its result")

endmodule

/* rtl/i2c_register_table_slave.sv */
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+----------------------------
// in       | in_valid_i / in_ready_o         | in_req_i  (i2crt_pkg::in_req_t)
// out      | out_valid_o / out_ready_i       | out_rsp_o (i2crt_pkg::out_rsp_t)
// cfg      | psel, penable, pwrite / pready  | paddr, pwdata, prdata
//
// Each request is accepted in ST_IDLE, where the buffer and length
// memories are read, and committed in ST_EXEC, where the result and
// position state are updated; the registered memory reads need both.
// After reset a clearing sweep over all NUM_REGS*BUF_DEPTH entries
// zeroes the memories; no request is accepted until it ends.
// A result waiting on out_ready_i holds the commit cycle until it is taken.
module i2c_register_table_slave #(
  parameter int unsigned NUM_REGS  = i2crt_pkg::NUM_REGS_DEF,
  parameter int unsigned BUF_DEPTH = i2crt_pkg::BUF_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  i2crt_pkg::in_req_t               in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output i2crt_pkg::out_rsp_t              out_rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [i2crt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [i2crt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [i2crt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);

  i2crt_pkg::ctrl_cmd_t  cmd;
  i2crt_pkg::dp_status_t status;
  logic [3:0]            table_entries;

  i2crt_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .table_entries_o (table_entries)
  );

  i2crt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  i2crt_dp #(
    .NUM_REGS  (NUM_REGS),
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .table_entries_i (table_entries),
    .in_req_i        (in_req_i),
    .out_rsp_o       (out_rsp_o)
  );

endmodule
